// ===== rtl/double_ended_queue_defines.svh =====
// Assertion macros shared by the double-ended queue RTL.
`ifndef DOUBLE_ENDED_QUEUE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_DEFINES_SVH

// Check a property on a given clock, disabled while the active-low reset is asserted.
`define DEQ_ASSERT_AT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check a property on the block clock and reset.
`define DEQ_ASSERT(lbl, prop, msg) \
  `DEQ_ASSERT_AT(lbl, clk_i, rst_ni, prop, msg)

`endif

// ===== rtl/deq_pkg.sv =====
package deq_pkg;

  // Queue geometry
  localparam int DEPTH    = 64;
  localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int SUM_W    = CNT_W + 1;
  localparam int VALUE_W  = 32;
  localparam int CMD_W    = 3;
  localparam int STATUS_W = 2;

  typedef logic [STATUS_W-1:0] deq_status_t;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DUMP       = 3'd4;

  // Status codes
  localparam deq_status_t ST_OK    = 2'd0;
  localparam deq_status_t ST_EMPTY = 2'd1;
  localparam deq_status_t ST_FULL  = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic        push_front;
    logic        push_back;
    logic        pop_front;
    logic        pop_back;
    logic        dump_start;
    logic        dump_issue;
    logic        load_result;
    logic        load_from_ram;
    deq_status_t result_status;
    logic        result_last;
  } deq_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic full;
    logic empty;
    logic issued_all;
    logic issue_last;
  } deq_sts_t;

  // Ring slot at a given offset from base, wrapped at DEPTH
  function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] base,
                                               input logic [CNT_W-1:0] off);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(off);
    if (sum >= SUM_W'(DEPTH)) begin
      sum = sum - SUM_W'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

// ===== rtl/deq_ram.sv =====
module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read, held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/deq_dp.sv =====
`include "double_ended_queue_defines.svh"

module deq_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic signed [deq_pkg::VALUE_W-1:0] value_i,
  input  deq_pkg::deq_cmd_t              cmd_i,
  output deq_pkg::deq_sts_t              sts_o,
  output logic signed [deq_pkg::VALUE_W-1:0] element_o,
  output deq_pkg::deq_status_t           status_o,
  output logic                           last_of_run_o
);
  import deq_pkg::*;

  logic [IDX_W-1:0]   front_q, front_d, front_dec;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [CNT_W-1:0]   idx_q, idx_d;
  logic [IDX_W-1:0]   wr_addr, rd_addr;
  logic               ram_we;
  logic [VALUE_W-1:0] ram_rdata;
  logic signed [VALUE_W-1:0] element_q;
  deq_status_t        status_q;
  logic               last_q;

  // Address generation
  always_comb begin
    front_dec = (front_q == '0) ? IDX_W'(DEPTH - 1) : front_q - 1'b1;
    wr_addr   = cmd_i.push_front ? front_dec : wrap_add(front_q, count_q);
    rd_addr   = wrap_add(front_q, idx_q);
    ram_we    = cmd_i.push_front | cmd_i.push_back;
  end

  // Advance front index, element count and dump index
  always_comb begin
    front_d = front_q;
    count_d = count_q;
    idx_d   = idx_q;
    if (cmd_i.push_front) begin
      front_d = front_dec;
    end else if (cmd_i.pop_front) begin
      front_d = wrap_add(front_q, CNT_W'(1));
    end
    if (cmd_i.push_front || cmd_i.push_back) begin
      count_d = count_q + 1'b1;
    end else if (cmd_i.pop_front || cmd_i.pop_back) begin
      count_d = count_q - 1'b1;
    end
    if (cmd_i.dump_start) begin
      idx_d = '0;
    end else if (cmd_i.dump_issue) begin
      idx_d = idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      count_q <= '0;
      idx_q   <= '0;
    end else begin
      front_q <= front_d;
      count_q <= count_d;
      idx_q   <= idx_d;
    end
  end

  // Element storage
  deq_ram #(
    .WIDTH(VALUE_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(wr_addr),
    .wdata_i(value_i),
    .re_i   (cmd_i.dump_issue),
    .raddr_i(rd_addr),
    .rdata_o(ram_rdata)
  );

  // Status toward the controller
  always_comb begin
    sts_o.full       = (count_q == CNT_W'(DEPTH));
    sts_o.empty      = (count_q == '0);
    sts_o.issued_all = (idx_q == count_q);
    sts_o.issue_last = ((idx_q + 1'b1) == count_q);
  end

  // Output payload register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_result) begin
      element_q <= cmd_i.load_from_ram ? signed'(ram_rdata) : '0;
      status_q  <= cmd_i.result_status;
      last_q    <= cmd_i.result_last;
    end
  end

  assign element_o     = element_q;
  assign status_o      = status_q;
  assign last_of_run_o = last_q;

  `DEQ_ASSERT(a_count_bound, count_q <= CNT_W'(DEPTH), "element count exceeds depth")
  `DEQ_ASSERT(a_idx_cleared, cmd_i.dump_start |=> (idx_q == '0), "dump index not cleared")
  `DEQ_ASSERT(a_issue_in_range, cmd_i.dump_issue |-> (idx_q < count_q), "dump read beyond tail")

endmodule

// ===== rtl/deq_ctrl.sv =====
`include "double_ended_queue_defines.svh"

module deq_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [deq_pkg::CMD_W-1:0]   command_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output deq_pkg::deq_cmd_t           cmd_o,
  input  deq_pkg::deq_sts_t           sts_i
);
  import deq_pkg::*;

  localparam logic [0:0] S_IDLE = 1'b0;
  localparam logic [0:0] S_DUMP = 1'b1;

  logic [0:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       pend_q, pend_d;
  logic       pend_last_q, pend_last_d;
  logic       out_free;
  logic       accept;
  logic       load_out;
  logic       issue;

  // Handshake on the input side
  always_comb begin
    out_free   = !out_valid_q || !out_stall_i;
    in_stall_o = !((state_q == S_IDLE) && out_free);
    accept     = in_valid_i && !in_stall_o;
  end

  // Command decode and dump sequencing
  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    pend_d      = pend_q;
    pend_last_d = pend_last_q;
    load_out    = 1'b0;
    issue       = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (command_i)
            CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
              cmd_o.load_result = 1'b1;
              cmd_o.result_last = 1'b1;
              if (sts_i.full) begin
                cmd_o.result_status = ST_FULL;
              end else begin
                cmd_o.result_status = ST_OK;
                cmd_o.push_front    = (command_i == CMD_PUSH_FRONT);
                cmd_o.push_back     = (command_i == CMD_PUSH_BACK);
              end
            end
            CMD_POP_FRONT, CMD_POP_BACK: begin
              cmd_o.load_result = 1'b1;
              cmd_o.result_last = 1'b1;
              if (sts_i.empty) begin
                cmd_o.result_status = ST_EMPTY;
              end else begin
                cmd_o.result_status = ST_OK;
                cmd_o.pop_front     = (command_i == CMD_POP_FRONT);
                cmd_o.pop_back      = (command_i == CMD_POP_BACK);
              end
            end
            CMD_DUMP: begin
              if (sts_i.empty) begin
                cmd_o.load_result   = 1'b1;
                cmd_o.result_last   = 1'b1;
                cmd_o.result_status = ST_EMPTY;
              end else begin
                cmd_o.dump_start = 1'b1;
                pend_d           = 1'b0;
                state_d          = S_DUMP;
              end
            end
            default: begin
              // drop undefined commands
            end
          endcase
        end
      end
      S_DUMP: begin
        load_out = pend_q && out_free;
        issue    = !sts_i.issued_all && (!pend_q || load_out);
        if (load_out) begin
          cmd_o.load_result   = 1'b1;
          cmd_o.load_from_ram = 1'b1;
          cmd_o.result_status = ST_OK;
          cmd_o.result_last   = pend_last_q;
        end
        if (issue) begin
          cmd_o.dump_issue = 1'b1;
          pend_d           = 1'b1;
          pend_last_d      = sts_i.issue_last;
        end else if (load_out) begin
          pend_d = 1'b0;
        end
        if (load_out && pend_last_q) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold the result until the consumer takes it
  always_comb begin
    if (cmd_o.load_result) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
      pend_last_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      pend_q      <= pend_d;
      pend_last_q <= pend_last_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `DEQ_ASSERT(a_no_overwrite, (out_valid_q && out_stall_i) |-> !cmd_o.load_result, "result overwritten while stalled")
  `DEQ_ASSERT(a_pend_in_dump, pend_q |-> (state_q == S_DUMP), "read pending outside dump")
  `DEQ_ASSERT(a_push_not_full, (cmd_o.push_front || cmd_o.push_back) |-> !sts_i.full, "push into full queue")

endmodule

// ===== rtl/double_ended_queue.sv =====
// Bounded double-ended queue of DEPTH (64) signed 32-bit elements in a ring buffer.
// Each accepted transaction is one command: push front, push back, pop front,
// pop back or dump; codes 5 to 7 are dropped with no result. Push and pop return
// one result with status ok, empty or full, and sustain one transaction per cycle
// while results are taken. A dump of N elements returns N results front to back,
// the last one flagged: the accepting cycle starts it, the first read of the
// element RAM follows, which is registered, then one element per cycle through
// its single read port while results are taken; the input stays stalled until
// the last element is loaded into the output register.
// Results wait in an output register; output stall backs up into input stall.
module double_ended_queue (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [deq_pkg::CMD_W-1:0]          command_i,
  input  logic signed [deq_pkg::VALUE_W-1:0] value_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [deq_pkg::VALUE_W-1:0] element_o,
  output logic [deq_pkg::STATUS_W-1:0]       status_o,
  output logic                               last_of_run_o
);
  import deq_pkg::*;

  deq_cmd_t cmd;
  deq_sts_t sts;

  // Control sequencer
  deq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .command_i  (command_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  // Indices, storage and result register
  deq_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .value_i      (value_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .element_o    (element_o),
    .status_o     (status_o),
    .last_of_run_o(last_of_run_o)
  );

endmodule

// ===== dv/double_ended_queue_tb.sv =====
module double_ended_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import deq_pkg::*;

  localparam int RANDOM_ITEMS = 330;
  localparam int STALL_LIMIT  = 2000;
  localparam int N_DIRECTED   = 23;

  // Codes outside the command set; the block drops them with no result
  localparam logic [CMD_W-1:0] CMD_UNUSED_5 = 3'd5;
  localparam logic [CMD_W-1:0] CMD_UNUSED_6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_UNUSED_7 = 3'd7;

  typedef struct packed {
    logic signed [VALUE_W-1:0] element;
    deq_status_t               status;
    logic                      last;
  } queue_result_t;

  typedef struct packed {
    logic [CMD_W-1:0]          cmd;
    logic signed [VALUE_W-1:0] value;
    bit                        fixed_want;
    deq_status_t               want_status;
  } stim_row_t;

  logic                        clk_i       = 1'b0;
  logic                        rst_ni      = 1'b0;
  logic                        in_valid_i  = 1'b0;
  logic [CMD_W-1:0]            command_i   = CMD_PUSH_FRONT;
  logic signed [VALUE_W-1:0]   value_i     = '0;
  logic                        out_stall_i = 1'b0;
  logic                        in_stall_o;
  logic                        out_valid_o;
  logic signed [VALUE_W-1:0]   element_o;
  logic [STATUS_W-1:0]         status_o;
  logic                        last_of_run_o;

  // Shadow copy of the ring buffer
  logic signed [VALUE_W-1:0]   slot_values [DEPTH];
  int                          head_slot;
  int                          stored_count;

  queue_result_t               fresh_results [$];
  queue_result_t               awaited_results [$];
  int                          mismatches;
  int                          items_sent;
  bit                          quiet_stretch;

  // Rows with a fixed status carry an expectation readable at a glance
  stim_row_t directed_rows [N_DIRECTED] = '{
    '{CMD_DUMP,       32'sh0000_0000, 1'b1, ST_EMPTY},
    '{CMD_POP_FRONT,  32'sh0000_0000, 1'b1, ST_EMPTY},
    '{CMD_POP_BACK,   32'shFFFF_FFFF, 1'b1, ST_EMPTY},
    '{CMD_UNUSED_5,   32'sh0000_0000, 1'b0, ST_OK},
    '{CMD_PUSH_BACK,  32'sh7FFF_FFFF, 1'b1, ST_OK},
    '{CMD_PUSH_FRONT, 32'sh8000_0000, 1'b1, ST_OK},
    '{CMD_PUSH_BACK,  32'sh0000_0000, 1'b1, ST_OK},
    '{CMD_PUSH_FRONT, 32'shFFFF_FFFF, 1'b1, ST_OK},
    '{CMD_UNUSED_6,   32'shFFFF_FFFF, 1'b0, ST_OK},
    '{CMD_DUMP,       32'sh0000_0000, 1'b0, ST_OK},
    '{CMD_POP_FRONT,  32'sh0000_0000, 1'b1, ST_OK},
    '{CMD_POP_BACK,   32'sh0000_0000, 1'b1, ST_OK},
    '{CMD_DUMP,       32'shFFFF_FFFF, 1'b0, ST_OK},
    '{CMD_UNUSED_7,   32'sh5555_5555, 1'b0, ST_OK},
    '{CMD_PUSH_BACK,  32'sh5555_5555, 1'b1, ST_OK},
    '{CMD_PUSH_FRONT, 32'shAAAA_AAAA, 1'b1, ST_OK},
    '{CMD_DUMP,       32'sh0000_0000, 1'b0, ST_OK},
    '{CMD_POP_BACK,   32'sh0000_0000, 1'b1, ST_OK},
    '{CMD_POP_BACK,   32'sh0000_0000, 1'b1, ST_OK},
    '{CMD_POP_BACK,   32'sh0000_0000, 1'b1, ST_OK},
    '{CMD_POP_FRONT,  32'sh0000_0000, 1'b1, ST_OK},
    '{CMD_POP_FRONT,  32'sh0000_0000, 1'b1, ST_EMPTY},
    '{CMD_DUMP,       32'shFFFF_FFFF, 1'b1, ST_EMPTY}
  };

  double_ended_queue u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .command_i     (command_i),
    .value_i       (value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .element_o     (element_o),
    .status_o      (status_o),
    .last_of_run_o (last_of_run_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Apply one command to the shadow queue and collect the results it yields
  function automatic void apply_command(input logic [CMD_W-1:0] cmd,
                                        input logic signed [VALUE_W-1:0] val);
    queue_result_t r;
    fresh_results.delete();
    r = '{element: '0, status: ST_OK, last: 1'b1};
    case (cmd)
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (stored_count >= DEPTH) begin
          r.status = ST_FULL;
        end else if (cmd == CMD_PUSH_FRONT) begin
          head_slot = (head_slot + DEPTH - 1) % DEPTH;
          slot_values[head_slot] = val;
          stored_count++;
        end else begin
          slot_values[(head_slot + stored_count) % DEPTH] = val;
          stored_count++;
        end
        fresh_results.push_back(r);
      end
      CMD_POP_FRONT, CMD_POP_BACK: begin
        if (stored_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          if (cmd == CMD_POP_FRONT) head_slot = (head_slot + 1) % DEPTH;
          stored_count--;
        end
        fresh_results.push_back(r);
      end
      CMD_DUMP: begin
        if (stored_count == 0) begin
          r.status = ST_EMPTY;
          fresh_results.push_back(r);
        end else begin
          for (int i = 0; i < stored_count; i++) begin
            r.element = slot_values[(head_slot + i) % DEPTH];
            r.last    = (i == stored_count - 1);
            fresh_results.push_back(r);
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic int draw_wait();
    return quiet_stretch ? 0 : $urandom_range(0, 3);
  endfunction

  function automatic logic signed [VALUE_W-1:0] random_value();
    case ($urandom_range(0, 11))
      0:       return {1'b0, {(VALUE_W-1){1'b1}}};
      1:       return {1'b1, {(VALUE_W-1){1'b0}}};
      2:       return '0;
      3:       return '1;
      default: return $urandom();
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // Present one transaction, wait for acceptance, then record what it should yield.
  // Entered and left at a falling edge.
  task automatic send_command(input logic [CMD_W-1:0] cmd,
                              input logic signed [VALUE_W-1:0] val,
                              input bit fixed_want = 1'b0,
                              input deq_status_t want_status = ST_OK);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      command_i  <= CMD_W'($urandom());
      value_i    <= $urandom();
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i  <= cmd;
    value_i    <= val;
    do @(posedge clk_i); while (in_stall_o);
    apply_command(cmd, val);
    if (fixed_want) begin
      awaited_results.push_back('{element: '0, status: want_status, last: 1'b1});
    end else begin
      foreach (fresh_results[k]) awaited_results.push_back(fresh_results[k]);
    end
    if (cmd <= CMD_DUMP) items_sent++;
    @(negedge clk_i);
  endtask

  // Hold the input idle until every outstanding result has come back
  task automatic await_all_results();
    in_valid_i <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Push to the brim with random content, then knock on the full queue
  task automatic fill_queue();
    while (stored_count < DEPTH) begin
      send_command($urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK, random_value());
    end
    repeat ($urandom_range(1, 3)) begin
      send_command($urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK, random_value());
    end
  endtask

  // Pop until empty from random ends, then pop past the bottom
  task automatic drain_queue();
    while (stored_count > 0) begin
      send_command($urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_BACK, random_value());
    end
    repeat ($urandom_range(1, 2)) begin
      send_command($urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_BACK, random_value());
    end
  endtask

  // Compare each accepted result with the oldest expectation
  always @(posedge clk_i) begin : result_check
    queue_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (awaited_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result element %0d status %0d last %0b",
                                  element_o, status_o, last_of_run_o));
      end else begin
        want = awaited_results.pop_front();
        if (element_o !== want.element)
          report_mismatch($sformatf("element got %0d want %0d", element_o, want.element));
        if (status_o !== want.status)
          report_mismatch($sformatf("status got %0d want %0d", status_o, want.status));
        if (last_of_run_o !== want.last)
          report_mismatch($sformatf("last_of_run got %0b want %0b",
                                    last_of_run_o, want.last));
      end
    end
  end

  // Stall the result side for a random while before taking each result
  initial begin : result_sink
    int hold;
    wait (rst_ni);
    @(negedge clk_i);
    forever begin
      hold = draw_wait();
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
      @(negedge clk_i);
    end
  end

  // Alternate between stretches with random gaps and full-rate stretches
  initial begin : pace_toggle
    forever begin
      repeat ($urandom_range(10, 60)) @(posedge clk_i);
      quiet_stretch = ($urandom_range(0, 2) == 0);
    end
  end

  // End the run when no transaction moves for too long
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int pick;
    bit paused;
    paused       = 1'b0;
    head_slot    = 0;
    stored_count = 0;
    mismatches   = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty cases, extremes, every command, dropped codes, front wrap
    foreach (directed_rows[i]) begin
      send_command(directed_rows[i].cmd, directed_rows[i].value,
                   directed_rows[i].fixed_want, directed_rows[i].want_status);
    end

    // Open the random part with a full cycle: fill, refuse, dump all, drain
    items_sent = 0;
    fill_queue();
    send_command(CMD_DUMP, random_value());
    drain_queue();

    while (items_sent < RANDOM_ITEMS) begin
      if (!paused && items_sent >= RANDOM_ITEMS / 2) begin
        paused = 1'b1;
        await_all_results();
      end
      pick = $urandom_range(0, 39);
      if (pick == 0) begin
        fill_queue();
      end else if (pick == 1) begin
        drain_queue();
      end else if (pick < 5) begin
        send_command(CMD_DUMP, random_value());
      end else if (pick < 7) begin
        send_command(CMD_W'($urandom_range(CMD_UNUSED_5, CMD_UNUSED_7)), random_value());
      end else if ($urandom_range(0, DEPTH) >= stored_count) begin
        // Lean toward growth while short, toward shrinking while long
        send_command($urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK, random_value());
      end else begin
        send_command($urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_BACK, random_value());
      end
    end

    await_all_results();
    repeat (DEPTH + 8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/deq_pkg.sv
rtl/deq_ram.sv
rtl/deq_dp.sv
rtl/deq_ctrl.sv
rtl/double_ended_queue.sv
dv/double_ended_queue_tb.sv
